/* rtl/priority_packet_rule_matcher_top_defines.svh */
// Assertion macros shared by the rule matcher RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PRIORITY_PACKET_RULE_MATCHER_TOP_DEFINES_SVH
`define PRIORITY_PACKET_RULE_MATCHER_TOP_DEFINES_SVH

// Clocked check, muted while reset is high
`define PPRM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define PPRM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pprm_pkg.sv */
// Shared types and codes for the priority packet rule matcher.
// Used by pprm_cell and priority_packet_rule_matcher_top; no dependencies.
package pprm_pkg;

   // Table depth default
   localparam int NUM_RULES_DEF = 32;

   // Request codes carried in req_tuser
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_EVAL   = 2'd2;

   // Rule wildcards
   localparam logic [1:0] DIR_ANY    = 2'd2;
   localparam logic [1:0] PROTO_WILD = 2'd0;

   // Port widths
   localparam int REQ_TDATA_W = 192;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int SLOT_W      = 5;
   localparam int IDX_W       = 5;

   // One rule, or the header fields of one packet
   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] src_netmask;
      logic [31:0] dst_ip;
      logic [31:0] dst_netmask;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  proto;
      logic [1:0]  direction;
      logic [15:0] priority_req;
      logic        action;
   } rule_type;

   // Per-cell write controls
   typedef struct packed {
      logic add_en;
      logic rem_en;
   } cell_ctl_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [15:0] low_pri;
      logic        allow;
   } tok_type;

   // Result item, status in the lowest bit
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               allow;
      logic               status;
   } rsp_type;

endpackage

/* rtl/pprm_cell.sv */
// One rule slot of the matcher chain: holds a rule and its active bit,
// and updates the search token passing through it. Depends on pprm_pkg.
module pprm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pprm_pkg::cell_ctl_type ctl,
   input  pprm_pkg::rule_type    wr_rule,
   input  pprm_pkg::rule_type    pkt,
   input  pprm_pkg::tok_type     tok_in,
   output pprm_pkg::tok_type     tok_out
);

   logic                active_ff;
   pprm_pkg::rule_type  rule_ff;
   pprm_pkg::tok_type   tok_ff;
   pprm_pkg::tok_type   tok_in_upd;

   logic dir_ok, proto_ok, src_ok, dst_ok, sport_ok, dport_ok, hit;

   // Field matches against the broadcast packet
   always_comb begin
      dir_ok   = (rule_ff.direction == pprm_pkg::DIR_ANY) ||
                 (rule_ff.direction == pkt.direction);
      proto_ok = (rule_ff.proto == pprm_pkg::PROTO_WILD) || (rule_ff.proto == pkt.proto);
      src_ok   = (rule_ff.src_ip == 32'd0) ||
                 ((pkt.src_ip & rule_ff.src_netmask) ==
                  (rule_ff.src_ip & rule_ff.src_netmask));
      dst_ok   = (rule_ff.dst_ip == 32'd0) ||
                 ((pkt.dst_ip & rule_ff.dst_netmask) ==
                  (rule_ff.dst_ip & rule_ff.dst_netmask));
      sport_ok = (rule_ff.sport == 16'd0) || (rule_ff.sport == pkt.sport);
      dport_ok = (rule_ff.dport == 16'd0) || (rule_ff.dport == pkt.dport);
      hit      = active_ff && dir_ok && proto_ok && src_ok && dst_ok && sport_ok && dport_ok;
   end

   // Strictly lower priority takes over; an earlier cell keeps a tie
   always_comb begin
      tok_in_upd = tok_in;
      if (hit && (!tok_in.found || (rule_ff.priority_req < tok_in.low_pri))) begin
         tok_in_upd.found   = 1'b1;
         tok_in_upd.low_pri = rule_ff.priority_req;
         tok_in_upd.allow   = rule_ff.action;
      end
   end

   // Active bit and token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         tok_ff    <= '0;
      end else begin
         if (ctl.add_en) begin
            active_ff <= 1'b1;
         end else if (ctl.rem_en) begin
            active_ff <= 1'b0;
         end
         tok_ff <= tok_in_upd;
      end
   end

   // Rule payload
   always_ff @(posedge clock) begin
      if (ctl.add_en) begin
         rule_ff <= wr_rule;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* rtl/priority_packet_rule_matcher_top.sv */
// Priority packet rule matcher: a table of NUM_RULES five-tuple rules built as a row of
// cells, one rule per cell. The block takes one item at a time. Add, remove and unknown
// requests answer in the cycle after they are accepted. An evaluate request sends a search
// token down the row of cells, one cell per clock, and its answer is registered when the
// token leaves the last cell, or held until the result register is free. A new item is
// accepted once the previous one has finished and the result register is free or being
// taken. Reset empties the table at once; no clearing pass is needed.
// Depends on pprm_pkg, pprm_cell and priority_packet_rule_matcher_top_defines.svh.
`include "priority_packet_rule_matcher_top_defines.svh"

module priority_packet_rule_matcher_top #(
   parameter int NUM_RULES = pprm_pkg::NUM_RULES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tuser: [1:0] req_type
   input  logic [pprm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // req_tdata: [4:0] rule_index, [36:5] source address, [68:37] source mask,
   // [100:69] destination address, [132:101] destination mask, [148:133] source port,
   // [164:149] destination port, [166:165] proto, [168:167] direction,
   // [184:169] priority_req, [185] action, [191:186] zero
   input  logic [pprm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: [0] status, [1] allow, [6:2] slot, [7] zero
   output logic [pprm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   localparam int UsedW = $clog2(NUM_RULES + 1);
   localparam int CmpW  = (UsedW > pprm_pkg::IDX_W) ? UsedW : pprm_pkg::IDX_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_type;

   state_type                  state_ff, state_in;
   logic [UsedW-1:0]           used_ff, used_in;
   pprm_pkg::rule_type         pkt_ff, pkt_in;
   pprm_pkg::tok_type          tok0_ff, tok0_in;
   pprm_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       held_allow_ff, held_allow_in;

   pprm_pkg::rule_type         req_rule;
   logic [1:0]                 req_type;
   logic [pprm_pkg::IDX_W-1:0] req_idx;
   logic                       acc, rsp_free, full, idx_ok, add_go, tok_last;
   logic [UsedW-1:0]           used_inc;

   pprm_pkg::tok_type          tok_chain [NUM_RULES+1];
   pprm_pkg::cell_ctl_type     cell_ctl  [NUM_RULES];
   logic [NUM_RULES-1:0]       tok_vld;

   // Unpack the request item
   always_comb begin
      req_type              = req_tuser[1:0];
      req_idx               = req_tdata[4:0];
      req_rule.src_ip       = req_tdata[36:5];
      req_rule.src_netmask  = req_tdata[68:37];
      req_rule.dst_ip       = req_tdata[100:69];
      req_rule.dst_netmask  = req_tdata[132:101];
      req_rule.sport        = req_tdata[148:133];
      req_rule.dport        = req_tdata[164:149];
      req_rule.proto        = req_tdata[166:165];
      req_rule.direction    = req_tdata[168:167];
      req_rule.priority_req = req_tdata[184:169];
      req_rule.action       = req_tdata[185];
   end

   // Handshake and table status
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign acc        = req_tvalid && req_tready;
   assign full       = (used_ff == UsedW'(NUM_RULES));
   assign idx_ok     = CmpW'(req_idx) < CmpW'(used_ff);
   assign add_go     = acc && (req_type == pprm_pkg::REQ_ADD) && !full;
   assign used_inc   = used_ff + UsedW'(1);
   assign tok_last   = tok_chain[NUM_RULES].valid;

   // Sequencer: next state, fill count and result register
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      pkt_in        = pkt_ff;
      tok0_in       = '0;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      held_allow_in = held_allow_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               rsp_in = '0;
               case (req_type)
                  pprm_pkg::REQ_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        rsp_in.slot = pprm_pkg::SLOT_W'(used_ff);
                        used_in     = used_inc;
                     end
                  end
                  pprm_pkg::REQ_REMOVE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = !idx_ok;
                  end
                  pprm_pkg::REQ_EVAL: begin
                     pkt_in        = req_rule;
                     tok0_in.valid = 1'b1;
                     tok0_in.allow = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Token leaves the last cell
            if (tok_last) begin
               if (rsp_free) begin
                  rsp_in       = '0;
                  rsp_in.allow = tok_chain[NUM_RULES].allow;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  held_allow_in = tok_chain[NUM_RULES].allow;
                  state_in      = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_in       = '0;
               rsp_in.allow = held_allow_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tok0_ff      <= tok0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pkt_ff        <= pkt_in;
      rsp_ff        <= rsp_in;
      held_allow_ff <= held_allow_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // Row of rule cells
   assign tok_chain[0] = tok0_ff;

   for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
      always_comb begin
         cell_ctl[g].add_en = add_go && (used_ff == UsedW'(g));
         cell_ctl[g].rem_en = acc && (req_type == pprm_pkg::REQ_REMOVE) && idx_ok &&
                              (CmpW'(req_idx) == CmpW'(g));
      end

      pprm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl[g]),
         .wr_rule (req_rule),
         .pkt     (pkt_ff),
         .tok_in  (tok_chain[g]),
         .tok_out (tok_chain[g+1])
      );

      assign tok_vld[g] = tok_chain[g+1].valid;
   end

   // Checks
   `PPRM_ASSERT(a_used_bound, clock, reset, used_ff <= UsedW'(NUM_RULES), "fill count past depth")
   `PPRM_ASSERT(a_one_tok, clock, reset, $onehot0({tok_vld, tok0_ff.valid}), "two tokens")
   `PPRM_ASSERT(a_tok_scan, clock, reset, tok_last |-> state_ff == ST_SCAN, "stray token")
   `PPRM_ASSERT(a_add_step, clock, reset, add_go |=> used_ff == $past(used_inc), "add lost")

endmodule
